// ===== rtl/core/psfc_pkg.sv =====
// shared types, constants and the cordic angle table of the pendulum controller
// no dependencies; imported by the core modules and the testbench
package psfc_pkg;

  localparam int OPW  = 34;   // multiplier operand width
  localparam int PRW  = 68;   // product width
  localparam int ACW  = 70;   // accumulator width
  localparam int CW   = 40;   // cordic x/y width
  localparam int ZW   = 26;   // cordic angle width, q.20 radians
  localparam int STEPS = 20;
  localparam int SCW  = 5;    // cordic step counter width

  localparam logic signed [CW-1:0]  GRAVITY_Q16     = 40'sd642689;
  localparam logic signed [CW-1:0]  CORDIC_GAIN_Q30 = 40'sd652032874;
  localparam logic signed [OPW-1:0] TWO_PI_Q20      = 34'sd6588397;
  localparam logic [31:0]           MIN_TIMEOUT_MS  = 32'd100;

  localparam logic [1:0] CMD_ODOM  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  localparam logic [2:0] ST_READY     = 3'd0;
  localparam logic [2:0] ST_DISABLED  = 3'd1;
  localparam logic [2:0] ST_NO_ODOM   = 3'd2;
  localparam logic [2:0] ST_NO_STATE  = 3'd3;
  localparam logic [2:0] ST_HEIGHT    = 3'd4;
  localparam logic [2:0] ST_NOT_READY = 3'd5;

  localparam logic [3:0] REG_ENABLE    = 4'd0;
  localparam logic [3:0] REG_SOURCE_ID = 4'd1;
  localparam logic [3:0] REG_GAIN_POS  = 4'd2;
  localparam logic [3:0] REG_GAIN_VEL  = 4'd3;
  localparam logic [3:0] REG_GAIN_POFS = 4'd4;
  localparam logic [3:0] REG_GAIN_PRT  = 4'd5;
  localparam logic [3:0] REG_HEIGHT_WIN = 4'd6;
  localparam logic [3:0] REG_ODOM_TMO  = 4'd7;

  typedef struct packed {
    logic mul;   // register a product
    logic acc;   // add the product register into the accumulator
    logic clr;   // accumulate onto zero
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic vec;   // vectoring when set, rotation otherwise
  } cordic_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  function automatic logic signed [ZW-1:0] atan_q20(input logic [SCW-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 26'sd823550;
      5'd1:  v = 26'sd486170;
      5'd2:  v = 26'sd256879;
      5'd3:  v = 26'sd130396;
      5'd4:  v = 26'sd65451;
      5'd5:  v = 26'sd32757;
      5'd6:  v = 26'sd16383;
      5'd7:  v = 26'sd8192;
      5'd8:  v = 26'sd4096;
      5'd9:  v = 26'sd2048;
      5'd10: v = 26'sd1024;
      5'd11: v = 26'sd512;
      5'd12: v = 26'sd256;
      5'd13: v = 26'sd128;
      5'd14: v = 26'sd64;
      5'd15: v = 26'sd32;
      5'd16: v = 26'sd16;
      5'd17: v = 26'sd8;
      5'd18: v = 26'sd4;
      5'd19: v = 26'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/psfc_if.sv =====
// valid/ready channels carrying input items and result items
// depends on psfc_pkg only for conventions; no parameters
interface psfc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [31:0]        time_ms;
  logic [7:0]         sender_id;
  logic               valid_req;
  logic signed [31:0] pos_north;
  logic signed [31:0] pos_east;
  logic signed [31:0] pos_down;
  logic signed [31:0] vel_north;
  logic signed [31:0] vel_east;
  logic signed [15:0] heading;
  logic [13:0]        lean_limit;
  modport source (output valid, command, time_ms, sender_id, valid_req, pos_north,
                  pos_east, pos_down, vel_north, vel_east, heading, lean_limit,
                  input ready);
  modport sink (input valid, command, time_ms, sender_id, valid_req, pos_north,
                pos_east, pos_down, vel_north, vel_east, heading, lean_limit,
                output ready);
endinterface

interface psfc_out_if;
  logic               valid;
  logic               ready;
  logic               active;
  logic [2:0]         status;
  logic signed [31:0] accel_north;
  logic signed [31:0] accel_east;
  logic signed [15:0] roll_target;
  logic signed [15:0] pitch_target;
  modport source (output valid, active, status, accel_north, accel_east, roll_target,
                  pitch_target, input ready);
  modport sink (input valid, active, status, accel_north, accel_east, roll_target,
                pitch_target, output ready);
endinterface

// ===== rtl/core/psfc_mac.sv =====
// shared signed multiplier with a product register and an accumulator
// depends on psfc_pkg
module psfc_mac import psfc_pkg::*; (
  input  logic                  clk,
  input  mac_ctl_t              ctl,
  input  logic signed [OPW-1:0] op_a,
  input  logic signed [OPW-1:0] op_b,
  output logic signed [PRW-1:0] prod,
  output logic signed [ACW-1:0] acc
);

  logic signed [PRW-1:0] prod_r;
  logic signed [ACW-1:0] acc_r;
  logic signed [ACW-1:0] acc_nxt;

  always_comb begin
    acc_nxt = (ctl.clr ? '0 : acc_r) + ACW'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= op_a * op_b;
    end
    if (ctl.acc) begin
      acc_r <= acc_nxt;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

// ===== rtl/core/psfc_cordic.sv =====
// one-step-per-cycle cordic, rotation or vectoring mode, twenty steps
// depends on psfc_pkg for widths and the angle table
module psfc_cordic import psfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cordic_req_t          req,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output cordic_sts_t          sts,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic signed [ZW-1:0] z
);

  logic                 busy_r, done_r, vec_r;
  logic [SCW-1:0]       cnt_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] da;
  logic                 fwd;

  always_comb begin
    dx  = y_r >>> cnt_r;
    dy  = x_r >>> cnt_r;
    da  = atan_q20(cnt_r);
    // rotate toward zero angle, or toward the x axis when vectoring
    fwd = vec_r ? y_r[CW-1] : ~z_r[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == SCW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      vec_r <= req.vec;
    end else if (busy_r) begin
      if (fwd) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - da;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + da;
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign x = x_r;
  assign y = y_r;
  assign z = z_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("cordic started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("cordic done while still busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r < SCW'(STEPS))
    else $error("cordic step count out of range");

endmodule

// ===== rtl/core/pendulum_state_feedback_controller_top.sv =====
// pendulum full-state feedback controller, top level with sequencer and state
// depends on psfc_pkg, psfc_if, psfc_mac and psfc_cordic
//
// usage:
//   in_ch carries items: pole odometry (command 0), control ticks (command 1)
//   and controller resets (command 2). odometry and resets update state at the
//   edge they are taken and produce no result. each control tick produces
//   exactly one result item on out_ch.
//   a gated-off or not-ready tick passes through gating and the output load
//   before its result is valid.
//   a tick that recomputes the feedback runs gating, 8 gain products (each a
//   multiply, then an accumulate) with a saturation per axis, heading scaling,
//   the rotation cordic (20 steps), 4 body-frame products with a rounding
//   after each pair, two vectoring passes and the output load.
//   a tick that reuses the held acceleration skips the gain products.
//   the next item can be taken in the cycle after the result loads.
//   in_ch.ready is high only while the sequencer is idle; a finished result
//   sits in the output register, so further items are taken while the receiver
//   stalls, and the next tick waits at its end until the register frees.
//   cfg_we writes register cfg_index with cfg_data; write only while idle.
//   reset (rst_n low, synchronous) restores register defaults and clears all
//   controller state but hold_r (relatched before use); no clearing pass is needed.
module pendulum_state_feedback_controller_top import psfc_pkg::*; #(
  parameter int CONTROL_INTERVAL = 5,
  parameter int MAX_STEP_MS      = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [19:0] cfg_data,
  psfc_in_if.sink     in_ch,
  psfc_out_if.source  out_ch
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_GATE  = 11'b00000000010,
    S_MAC   = 11'b00000000100,
    S_SAT   = 11'b00000001000,
    S_ZPREP = 11'b00000010000,
    S_ROT   = 11'b00000100000,
    S_BODY  = 11'b00001000000,
    S_BRND  = 11'b00010000000,
    S_VEC1  = 11'b00100000000,
    S_VEC2  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic        enable_r;
  logic [7:0]  source_id_r;
  logic [11:0] gain_pos_r, gain_vel_r;
  logic [12:0] gain_pofs_r, gain_prt_r;
  logic [19:0] height_win_r;
  logic [12:0] odom_tmo_r;

  // controller state
  logic               pole_seen_r;
  logic [31:0]        pole_time_r;
  logic signed [31:0] pole_pos_r [3];
  logic signed [31:0] pole_vel_r [2];
  logic [31:0]        step_time_r, control_time_r;
  logic signed [31:0] hold_r [2];
  logic               hold_valid_r;
  logic signed [31:0] held_r [2];

  // latched tick
  logic [31:0]        now_r;
  logic               valid_r;
  logic signed [31:0] pn_r, pe_r, pd_r, vn_r, ve_r;
  logic signed [15:0] hdg_r;
  logic [13:0]        lean_r;

  // sequencer
  logic [2:0]            op_r;
  logic                  ph_r;
  logic                  flip_r;
  logic                  act_r;
  logic [2:0]            st_r;
  logic signed [OPW-1:0] c_r, s_r;
  logic signed [CW-1:0]  fwd_r, right_r;
  logic signed [15:0]    roll_r, pitch_r;

  // output register
  logic               out_valid_r;
  logic               out_active_r;
  logic [2:0]         out_status_r;
  logic signed [31:0] out_an_r, out_ae_r;
  logic signed [15:0] out_roll_r, out_pitch_r;

  // shared units
  mac_ctl_t              mac_ctl;
  logic signed [OPW-1:0] mac_a, mac_b;
  logic signed [PRW-1:0] mac_prod;
  logic signed [ACW-1:0] mac_acc;
  cordic_req_t           cor_req;
  cordic_sts_t           cor_sts;
  logic signed [CW-1:0]  cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0]  cor_z0, cor_z;

  psfc_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .prod (mac_prod),
    .acc  (mac_acc)
  );

  psfc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .z0    (cor_z0),
    .sts   (cor_sts),
    .x     (cor_x),
    .y     (cor_y),
    .z     (cor_z)
  );

  logic in_acc, out_load;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // gating of a tick
  logic [31:0]        tmo, age, ctl_gap, dt;
  logic               timed_out, close, due;
  logic signed [32:0] hdiff;
  logic [32:0]        herr;
  logic [2:0]         gate_st;

  always_comb begin
    tmo       = ({19'b0, odom_tmo_r} < MIN_TIMEOUT_MS) ? MIN_TIMEOUT_MS : {19'b0, odom_tmo_r};
    age       = now_r - pole_time_r;
    timed_out = !pole_seen_r || (age > tmo);
    hdiff     = 33'(pole_pos_r[2]) - 33'(pd_r);
    herr      = hdiff[32] ? 33'(-hdiff) : 33'(hdiff);
    close     = valid_r && ((height_win_r == '0) || (herr < {13'b0, height_win_r}));
    ctl_gap   = now_r - control_time_r;
    due       = (control_time_r == '0) || (ctl_gap >= 32'(CONTROL_INTERVAL));
    dt        = now_r - step_time_r;
    priority if (!enable_r) gate_st = ST_DISABLED;
    else if (timed_out)     gate_st = ST_NO_ODOM;
    else if (!valid_r)      gate_st = ST_NO_STATE;
    else if (!close)        gate_st = ST_HEIGHT;
    else                    gate_st = ST_READY;
  end

  // heading fold into half circle
  logic signed [16:0] hfold;
  logic               hflip;
  always_comb begin
    hflip = 1'b0;
    hfold = 17'(hdg_r);
    if (hfold > 17'sd16384) begin
      hfold = hfold - 17'sd32768;
      hflip = 1'b1;
    end else if (hfold < -17'sd16384) begin
      hfold = hfold + 17'sd32768;
      hflip = 1'b1;
    end
  end

  // multiplier operand select
  logic               axis;
  logic [1:0]         term;
  logic signed [33:0] p_x, p_v, p_h, p_pp, p_pv;
  always_comb begin
    axis = op_r[2];
    term = op_r[1:0];
    p_x  = axis ? 34'(pe_r) : 34'(pn_r);
    p_v  = axis ? 34'(ve_r) : 34'(vn_r);
    p_h  = axis ? 34'(hold_r[1]) : 34'(hold_r[0]);
    p_pp = axis ? 34'(pole_pos_r[1]) : 34'(pole_pos_r[0]);
    p_pv = axis ? 34'(pole_vel_r[1]) : 34'(pole_vel_r[0]);
    mac_a = '0;
    mac_b = '0;
    unique case (state_r)
      S_MAC: begin
        unique case (term)
          2'd0: begin mac_a = p_h - p_x;  mac_b = {22'b0, gain_pos_r};  end
          2'd1: begin mac_a = -p_v;       mac_b = {22'b0, gain_vel_r};  end
          2'd2: begin mac_a = p_pp - p_x; mac_b = {21'b0, gain_pofs_r}; end
          default: begin mac_a = p_pv - p_v; mac_b = {21'b0, gain_prt_r}; end
        endcase
      end
      S_ZPREP: begin
        mac_a = 34'(hfold);
        mac_b = TWO_PI_Q20;
      end
      S_BODY: begin
        unique case (op_r[1:0])
          2'd0: begin mac_a = c_r;  mac_b = 34'(held_r[0]); end
          2'd1: begin mac_a = s_r;  mac_b = 34'(held_r[1]); end
          2'd2: begin mac_a = c_r;  mac_b = 34'(held_r[1]); end
          default: begin mac_a = -s_r; mac_b = 34'(held_r[0]); end
        endcase
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
    mac_ctl.mul = ((state_r == S_MAC) || (state_r == S_ZPREP) || (state_r == S_BODY)) && !ph_r;
    mac_ctl.acc = ((state_r == S_MAC) || (state_r == S_BODY)) && ph_r;
    mac_ctl.clr = (state_r == S_MAC) ? (term == 2'd0) : !op_r[0];
  end

  // roundings and limits
  logic signed [ACW-1:0] gain_rnd, body_rnd;
  logic signed [31:0]    sat_val;
  logic signed [PRW-1:0] z_rnd;
  logic signed [19:0]    ang, ang_neg, lim, pitch_c, roll_c;
  always_comb begin
    gain_rnd = (mac_acc + ACW'(128)) >>> 8;
    if (gain_rnd > ACW'(64'sh7FFF_FFFF))       sat_val = 32'sh7FFF_FFFF;
    else if (gain_rnd < -ACW'(64'sh8000_0000)) sat_val = 32'sh8000_0000;
    else                                       sat_val = gain_rnd[31:0];
    body_rnd = (mac_acc + (ACW'(1) <<< 29)) >>> 30;
    z_rnd    = (mac_prod + (PRW'(1) <<< 15)) >>> 16;
    ang      = 20'((cor_z + ZW'(64)) >>> 7);
    ang_neg  = -ang;
    lim      = {6'b0, lean_r};
    if (ang_neg > lim)       pitch_c = lim;
    else if (ang_neg < -lim) pitch_c = -lim;
    else                     pitch_c = ang_neg;
    if (ang > lim)           roll_c = lim;
    else if (ang < -lim)     roll_c = -lim;
    else                     roll_c = ang;
  end

  // cordic request
  always_comb begin
    cor_req.start = 1'b0;
    cor_req.vec   = 1'b1;
    cor_x0        = GRAVITY_Q16;
    cor_y0        = fwd_r;
    cor_z0        = '0;
    if ((state_r == S_ZPREP) && ph_r) begin
      cor_req.start = 1'b1;
      cor_req.vec   = 1'b0;
      cor_x0        = CORDIC_GAIN_Q30;
      cor_y0        = '0;
      cor_z0        = z_rnd[ZW-1:0];
    end else if ((state_r == S_BRND) && op_r[1]) begin
      cor_req.start = 1'b1;
    end else if ((state_r == S_VEC1) && cor_sts.done) begin
      cor_req.start = 1'b1;
      cor_y0        = right_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_ch.command == CMD_TICK) state_nxt = S_GATE;
      S_GATE: begin
        if (gate_st != ST_READY) state_nxt = S_EMIT;
        else if (!due) state_nxt = S_ZPREP;
        else if (step_time_r == '0) state_nxt = S_EMIT;
        else if (dt == '0 || dt > 32'(MAX_STEP_MS)) state_nxt = S_EMIT;
        else state_nxt = S_MAC;
      end
      S_MAC:   if (ph_r && term == 2'd3) state_nxt = S_SAT;
      S_SAT:   state_nxt = axis ? S_ZPREP : S_MAC;
      S_ZPREP: if (ph_r) state_nxt = S_ROT;
      S_ROT:   if (cor_sts.done) state_nxt = S_BODY;
      S_BODY:  if (ph_r && op_r[0]) state_nxt = S_BRND;
      S_BRND:  state_nxt = op_r[1] ? S_VEC1 : S_BODY;
      S_VEC1:  if (cor_sts.done) state_nxt = S_VEC2;
      S_VEC2:  if (cor_sts.done) state_nxt = S_EMIT;
      S_EMIT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      enable_r       <= 1'b1;
      source_id_r    <= 8'd42;
      gain_pos_r     <= 12'd51;
      gain_vel_r     <= 12'd102;
      gain_pofs_r    <= 13'd256;
      gain_prt_r     <= 13'd128;
      height_win_r   <= 20'd65536;
      odom_tmo_r     <= 13'd500;
      pole_seen_r    <= 1'b0;
      pole_time_r    <= '0;
      pole_pos_r[0]  <= '0;
      pole_pos_r[1]  <= '0;
      pole_pos_r[2]  <= '0;
      pole_vel_r[0]  <= '0;
      pole_vel_r[1]  <= '0;
      step_time_r    <= '0;
      control_time_r <= '0;
      hold_valid_r   <= 1'b0;
      held_r[0]      <= '0;
      held_r[1]      <= '0;
      out_valid_r    <= 1'b0;
      op_r           <= '0;
      ph_r           <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE:     enable_r     <= cfg_data[0];
          REG_SOURCE_ID:  source_id_r  <= cfg_data[7:0];
          REG_GAIN_POS:   gain_pos_r   <= cfg_data[11:0];
          REG_GAIN_VEL:   gain_vel_r   <= cfg_data[11:0];
          REG_GAIN_POFS:  gain_pofs_r  <= cfg_data[12:0];
          REG_GAIN_PRT:   gain_prt_r   <= cfg_data[12:0];
          REG_HEIGHT_WIN: height_win_r <= cfg_data;
          REG_ODOM_TMO:   odom_tmo_r   <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.command == CMD_ODOM && enable_r && in_ch.valid_req &&
              (source_id_r == '0 || in_ch.sender_id == source_id_r)) begin
            pole_pos_r[0] <= in_ch.pos_north;
            pole_pos_r[1] <= in_ch.pos_east;
            pole_pos_r[2] <= in_ch.pos_down;
            pole_vel_r[0] <= in_ch.vel_north;
            pole_vel_r[1] <= in_ch.vel_east;
            pole_time_r   <= in_ch.time_ms;
            pole_seen_r   <= 1'b1;
          end
          if (in_acc && in_ch.command == CMD_RESET) begin
            step_time_r    <= '0;
            control_time_r <= '0;
            held_r[0]      <= '0;
            held_r[1]      <= '0;
            hold_valid_r   <= 1'b0;
          end
        end
        S_GATE: begin
          op_r <= '0;
          ph_r <= 1'b0;
          if (gate_st != ST_READY) begin
            step_time_r    <= '0;
            control_time_r <= '0;
            held_r[0]      <= '0;
            held_r[1]      <= '0;
            hold_valid_r   <= 1'b0;
          end else if (due) begin
            step_time_r <= now_r;
            if (step_time_r != '0 && dt != '0 && dt <= 32'(MAX_STEP_MS)) begin
              control_time_r <= now_r;
              hold_valid_r   <= 1'b1;
            end
          end
        end
        S_MAC: begin
          ph_r <= !ph_r;
          if (ph_r && term != 2'd3) op_r <= op_r + 1'b1;
        end
        S_SAT: begin
          held_r[axis] <= sat_val;
          op_r         <= axis ? 3'd0 : 3'd4;
          ph_r         <= 1'b0;
        end
        S_ZPREP: begin
          ph_r <= !ph_r;
          op_r <= '0;
        end
        S_BODY: begin
          ph_r <= !ph_r;
          if (ph_r && !op_r[0]) op_r <= op_r + 1'b1;
        end
        S_BRND: begin
          if (!op_r[1]) op_r <= 3'd2;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r   <= in_ch.time_ms;
      valid_r <= in_ch.valid_req;
      pn_r    <= in_ch.pos_north;
      pe_r    <= in_ch.pos_east;
      pd_r    <= in_ch.pos_down;
      vn_r    <= in_ch.vel_north;
      ve_r    <= in_ch.vel_east;
      hdg_r   <= in_ch.heading;
      lean_r  <= in_ch.lean_limit;
    end
    if (state_r == S_GATE) begin
      // hold position latches on the first computed step after a clear
      if (gate_st == ST_READY && due && !hold_valid_r && step_time_r != '0 &&
          dt != '0 && dt <= 32'(MAX_STEP_MS)) begin
        hold_r[0] <= pn_r;
        hold_r[1] <= pe_r;
      end
      act_r   <= (gate_st == ST_READY);
      roll_r  <= '0;
      pitch_r <= '0;
      if (gate_st != ST_READY) st_r <= gate_st;
      else if (due && (step_time_r == '0 || dt == '0 || dt > 32'(MAX_STEP_MS))) begin
        st_r  <= ST_NOT_READY;
        act_r <= 1'b0;
      end else st_r <= ST_READY;
    end
    if (state_r == S_ZPREP && !ph_r) flip_r <= hflip;
    if (state_r == S_ROT && cor_sts.done) begin
      c_r <= flip_r ? OPW'(-cor_x) : OPW'(cor_x);
      s_r <= flip_r ? OPW'(-cor_y) : OPW'(cor_y);
    end
    if (state_r == S_BRND) begin
      if (op_r[1]) right_r <= body_rnd[CW-1:0];
      else         fwd_r   <= body_rnd[CW-1:0];
    end
    if (state_r == S_VEC1 && cor_sts.done) pitch_r <= pitch_c[15:0];
    if (state_r == S_VEC2 && cor_sts.done) roll_r  <= roll_c[15:0];
    if (out_load) begin
      out_active_r <= act_r;
      out_status_r <= st_r;
      out_an_r     <= act_r ? held_r[0] : '0;
      out_ae_r     <= act_r ? held_r[1] : '0;
      out_roll_r   <= act_r ? roll_r : '0;
      out_pitch_r  <= act_r ? pitch_r : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.active       = out_active_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.accel_north  = out_an_r;
  assign out_ch.accel_east   = out_ae_r;
  assign out_ch.roll_target  = out_roll_r;
  assign out_ch.pitch_target = out_pitch_r;

  a_tick_gates: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.command == CMD_TICK |=> state_r == S_GATE)
    else $error("tick not sequenced to gating");

  a_active_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.active |-> out_ch.status == ST_READY)
    else $error("active result with non-ready status");

  a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.active |-> out_ch.accel_north == '0 &&
    out_ch.accel_east == '0 && out_ch.roll_target == '0 && out_ch.pitch_target == '0)
    else $error("inactive result carries nonzero payload");

  a_mac_no_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> !cor_sts.busy)
    else $error("gain products overlap a cordic pass");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the pendulum state feedback controller top level
// needs psfc_pkg, psfc_if and the controller rtl; holds its own fixed point predictor
`timescale 1ns / 1ps

module tb_top;
  import psfc_pkg::*;

  localparam int N_RANDOM = 530;
  localparam int CALM_TAIL = 60;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 120;
  localparam int INTERVAL_MS = 5;
  localparam int MAX_GAP_MS = 1000;

  typedef struct {
    logic [1:0]         command;
    logic [31:0]        time_ms;
    logic [7:0]         sender_id;
    logic               valid_req;
    logic signed [31:0] pos_north;
    logic signed [31:0] pos_east;
    logic signed [31:0] pos_down;
    logic signed [31:0] vel_north;
    logic signed [31:0] vel_east;
    logic signed [15:0] heading;
    logic [13:0]        lean_limit;
  } item_t;

  typedef struct {
    logic               active;
    logic [2:0]         status;
    logic signed [31:0] accel_north;
    logic signed [31:0] accel_east;
    logic signed [15:0] roll_target;
    logic signed [15:0] pitch_target;
  } lean_cmd_t;

  typedef struct {
    item_t      it;
    bit         typed;
    logic [2:0] typed_status;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_index = REG_ENABLE;
  logic [19:0] cfg_data = '0;

  psfc_in_if in_ch ();
  psfc_out_if out_ch ();

  pendulum_state_feedback_controller_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of registers and controller state
  bit [0:0]  r_enable;
  bit [7:0]  r_source;
  bit [11:0] r_kx, r_kv;
  bit [12:0] r_kr, r_krd;
  bit [19:0] r_hwin;
  bit [12:0] r_tmo;
  bit        pole_seen, hold_valid;
  bit [31:0] pole_time, step_time, control_time;
  longint    pole_pos[3], pole_vel[2], hold_pos[2], held_acc[2];

  lean_cmd_t lean_cmds_due[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;
  bit hold_off_req = 0;
  row_t rows[$];

  longint atan_tab[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                           4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_lean(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint lean_of(longint a);
    longint x, y, z, dx, dy;
    x = 642689; y = a; z = 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return rnd_shift(z, 7);
  endfunction

  function automatic void clear_ctl();
    step_time = 0; control_time = 0;
    held_acc[0] = 0; held_acc[1] = 0;
    hold_valid = 0;
  endfunction

  function automatic void reset_model();
    r_enable = 1; r_source = 42; r_kx = 51; r_kv = 102; r_kr = 256; r_krd = 128;
    r_hwin = 65536; r_tmo = 500;
    pole_seen = 0; pole_time = 0;
    foreach (pole_pos[k]) pole_pos[k] = 0;
    pole_vel[0] = 0; pole_vel[1] = 0;
    hold_pos[0] = 0; hold_pos[1] = 0;
    clear_ctl();
  endfunction

  // returns 1 when the item yields a lean command
  function automatic bit predict_lean(item_t it, output lean_cmd_t r);
    bit [31:0] tmo, now, dt;
    bit timed_out, close, ok;
    longint herr, pos[2], vel[2], sum, s, c, x, y, z, dx, dy, h, an, ae, fwd, rgt;
    bit flip;
    logic [2:0] st;
    r = '{default: 0};
    now = it.time_ms;
    if (it.command == CMD_ODOM) begin
      if (r_enable && (r_source == 0 || it.sender_id == r_source) && it.valid_req) begin
        pole_pos[0] = it.pos_north; pole_pos[1] = it.pos_east; pole_pos[2] = it.pos_down;
        pole_vel[0] = it.vel_north; pole_vel[1] = it.vel_east;
        pole_time = now; pole_seen = 1;
      end
      return 0;
    end
    if (it.command == CMD_RESET) begin
      clear_ctl();
      return 0;
    end
    if (it.command != CMD_TICK) return 0;
    tmo = (r_tmo < 100) ? 32'd100 : 32'(r_tmo);
    timed_out = !pole_seen || (now - pole_time) > tmo;
    herr = pole_pos[2] - longint'(it.pos_down);
    if (herr < 0) herr = -herr;
    close = it.valid_req && (r_hwin == 0 || herr < longint'(r_hwin));
    if (!r_enable) st = ST_DISABLED;
    else if (timed_out) st = ST_NO_ODOM;
    else if (!it.valid_req) st = ST_NO_STATE;
    else if (!close) st = ST_HEIGHT;
    else st = ST_READY;
    if (st != ST_READY) begin
      clear_ctl();
    end else begin
      ok = 1;
      if (control_time == 0 || (now - control_time) >= INTERVAL_MS) begin
        if (step_time == 0) begin
          step_time = now; ok = 0;
        end else begin
          dt = now - step_time;
          step_time = now;
          if (dt == 0 || dt > MAX_GAP_MS) begin
            ok = 0;
          end else begin
            if (!hold_valid) begin
              hold_pos[0] = it.pos_north; hold_pos[1] = it.pos_east; hold_valid = 1;
            end
            pos[0] = it.pos_north; pos[1] = it.pos_east;
            vel[0] = it.vel_north; vel[1] = it.vel_east;
            for (int k = 0; k < 2; k++) begin
              sum = -(pos[k] - hold_pos[k]) * longint'(r_kx) - vel[k] * longint'(r_kv)
                    + (pole_pos[k] - pos[k]) * longint'(r_kr)
                    + (pole_vel[k] - vel[k]) * longint'(r_krd);
              held_acc[k] = sat32(rnd_shift(sum, 8));
            end
            control_time = now;
          end
        end
      end
      if (!ok) begin
        st = ST_NOT_READY;
      end else begin
        // heading folded into +-90 degrees before the rotation pass
        h = it.heading; flip = 0;
        if (h > 16384) begin
          h -= 32768; flip = 1;
        end else if (h < -16384) begin
          h += 32768; flip = 1;
        end
        z = rnd_shift(h * 6588397, 16);
        x = 652032874; y = 0;
        for (int i = 0; i < 20; i++) begin
          dx = y >>> i; dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
          end else begin
            x += dx; y -= dy; z += atan_tab[i];
          end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
        an = held_acc[0]; ae = held_acc[1];
        fwd = rnd_shift(c * an + s * ae, 30);
        rgt = rnd_shift(c * ae - s * an, 30);
        r.pitch_target = 16'(clamp_lean(-lean_of(fwd), longint'(it.lean_limit)));
        r.roll_target = 16'(clamp_lean(lean_of(rgt), longint'(it.lean_limit)));
        r.active = 1;
        r.accel_north = 32'(an);
        r.accel_east = 32'(ae);
      end
    end
    r.status = st;
    return 1;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    lean_cmd_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (lean_cmds_due.size() == 0) begin
        report("unexpected item, status", out_ch.status, 0);
      end else begin
        w = lean_cmds_due.pop_front();
        if (out_ch.active !== w.active) report("active", out_ch.active, w.active);
        if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
        if (out_ch.accel_north !== w.accel_north)
          report("accel_north", out_ch.accel_north, w.accel_north);
        if (out_ch.accel_east !== w.accel_east)
          report("accel_east", out_ch.accel_east, w.accel_east);
        if (out_ch.roll_target !== w.roll_target)
          report("roll_target", out_ch.roll_target, w.roll_target);
        if (out_ch.pitch_target !== w.pitch_target)
          report("pitch_target", out_ch.pitch_target, w.pitch_target);
      end
    end
  end

  // receiver side: short random stalls, one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_off_req = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pendulum_state_feedback_controller_top: mismatch");
      $finish;
    end
  end

  // valid stays high after an accept; the next item, an idle burst or a drain replaces it
  task automatic send(item_t it, bit typed, logic [2:0] typed_status);
    lean_cmd_t r;
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;
    in_ch.time_ms <= it.time_ms;
    in_ch.sender_id <= it.sender_id;
    in_ch.valid_req <= it.valid_req;
    in_ch.pos_north <= it.pos_north;
    in_ch.pos_east <= it.pos_east;
    in_ch.pos_down <= it.pos_down;
    in_ch.vel_north <= it.vel_north;
    in_ch.vel_east <= it.vel_east;
    in_ch.heading <= it.heading;
    in_ch.lean_limit <= it.lean_limit;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_lean(it, r)) begin
      if (typed && r.status !== typed_status) report("table status", r.status, typed_status);
      lean_cmds_due.push_back(r);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (lean_cmds_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE:     r_enable = val[0];
      REG_SOURCE_ID:  r_source = val[7:0];
      REG_GAIN_POS:   r_kx = val[11:0];
      REG_GAIN_VEL:   r_kv = val[11:0];
      REG_GAIN_POFS:  r_kr = val[12:0];
      REG_GAIN_PRT:   r_krd = val[12:0];
      REG_HEIGHT_WIN: r_hwin = val;
      REG_ODOM_TMO:   r_tmo = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic row_t row(logic [1:0] cmd, logic [31:0] t, logic [7:0] snd, logic vr,
                               logic [31:0] pn, logic [31:0] pe, logic [31:0] pd,
                               logic [31:0] vn, logic [31:0] ve, logic [15:0] hdg,
                               logic [13:0] lean, bit typed, logic [2:0] st);
    row_t r;
    r.it = '{cmd, t, snd, vr, pn, pe, pd, vn, ve, hdg, lean};
    r.typed = typed;
    r.typed_status = st;
    return r;
  endfunction

  function automatic logic [31:0] rnd_val(int wide);
    if (wide) return $urandom;
    return 32'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
  endfunction

  initial begin
    item_t it;
    logic [31:0] now;
    logic [31:0] pole_n, pole_e, pole_d;
    int k, sel, wide;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ODOM;
    in_ch.time_ms = '0;
    in_ch.sender_id = '0;
    in_ch.valid_req = 1'b0;
    in_ch.pos_north = '0;
    in_ch.pos_east = '0;
    in_ch.pos_down = '0;
    in_ch.vel_north = '0;
    in_ch.vel_east = '0;
    in_ch.heading = '0;
    in_ch.lean_limit = '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    rows.push_back(row(CMD_TICK, 1000, 42, 1, 0, 0, 0, 0, 0, 0, 2000, 1, ST_NO_ODOM));
    rows.push_back(row(CMD_ODOM, 1000, 42, 1, 32'h8000, 32'hFFFF8000, 0, 32'h4000,
                       32'hFFFFC000, 0, 0, 0, 0));
    rows.push_back(row(CMD_ODOM, 1000, 255, 1, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_ODOM, 1000, 42, 0, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_TICK, 1001, 0, 0, 0, 0, 0, 0, 0, 0, 2000, 1, ST_NO_STATE));
    rows.push_back(row(CMD_TICK, 1002, 0, 1, 0, 0, 32'h20000, 0, 0, 0, 2000, 1, ST_HEIGHT));
    rows.push_back(row(CMD_TICK, 1003, 0, 1, 0, 0, 0, 0, 0, 0, 2000, 1, ST_NOT_READY));
    rows.push_back(row(CMD_TICK, 1003, 0, 1, 0, 0, 0, 0, 0, 0, 2000, 1, ST_NOT_READY));
    rows.push_back(row(CMD_TICK, 1005, 0, 1, 32'h10000, 32'hFFFF0000, 0, 32'h20000,
                       32'h30000, 16'h1000, 16383, 1, ST_READY));
    rows.push_back(row(CMD_TICK, 1006, 0, 1, 0, 0, 0, 0, 0, 16'h7FFF, 16383, 1, ST_READY));
    rows.push_back(row(CMD_TICK, 1011, 0, 1, 32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000,
                       32'h7FFFFFFF, 16'h8000, 16383, 1, ST_READY));
    rows.push_back(row(CMD_TICK, 1016, 0, 1, 32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF,
                       32'h80000000, 16'hC000, 0, 1, ST_READY));
    rows.push_back(row(CMD_TICK, 1021, 0, 1, 32'h40000, 0, 32'hFFFF0001, 0, 0, 16'h4000,
                       3000, 1, ST_READY));
    rows.push_back(row(CMD_ODOM, 1400, 42, 1, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_TICK, 2200, 0, 1, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 2000, 1,
                       ST_NO_ODOM));
    rows.push_back(row(2'd3, 2200, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_ODOM, 32'hFFFFFFF0, 42, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_TICK, 32'hFFFFFFFF, 0, 1, 0, 0, 0, 0, 0, 0, 2000, 1,
                       ST_NOT_READY));
    rows.push_back(row(CMD_TICK, 4, 0, 1, 32'h50000, 0, 0, 0, 0, 16'h2000, 2000, 1, ST_READY));
    rows.push_back(row(CMD_RESET, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(CMD_TICK, 0, 0, 1, 0, 0, 0, 0, 0, 0, 2000, 1, ST_NOT_READY));
    rows.push_back(row(CMD_TICK, 6, 0, 1, 0, 0, 0, 0, 0, 0, 2000, 1, ST_NOT_READY));
    foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].typed_status);
    drain();

    now = 50000;
    pole_n = 0; pole_e = 0; pole_d = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      // configuration phases, only with the block drained
      if (i % 110 == 0 && i != 0) begin
        drain();
        k = i / 110;
        case (k)
          1: begin
            write_reg(REG_SOURCE_ID, 0);
            write_reg(REG_GAIN_POS, 2560);
            write_reg(REG_GAIN_VEL, 2560);
            write_reg(REG_GAIN_POFS, 5120);
            write_reg(REG_GAIN_PRT, 5120);
            write_reg(REG_HEIGHT_WIN, 0);
            write_reg(REG_ODOM_TMO, 100);
          end
          2: begin
            write_reg(REG_SOURCE_ID, 255);
            write_reg(REG_GAIN_POS, 0);
            write_reg(REG_GAIN_VEL, 0);
            write_reg(REG_GAIN_POFS, 0);
            write_reg(REG_GAIN_PRT, 0);
            write_reg(REG_HEIGHT_WIN, 655360);
            write_reg(REG_ODOM_TMO, 5000);
          end
          3: begin
            write_reg(REG_ENABLE, 0);
            write_reg(REG_SOURCE_ID, 170);
            write_reg(REG_GAIN_POS, 12'hAAA);
            write_reg(REG_GAIN_VEL, 12'h555);
            write_reg(REG_GAIN_POFS, 13'h0AAA);
            write_reg(REG_GAIN_PRT, 13'h1555);
            write_reg(REG_HEIGHT_WIN, 20'h55555);
            write_reg(REG_ODOM_TMO, 13'h0AAA);
          end
          4: begin
            write_reg(REG_ENABLE, 1);
            write_reg(REG_SOURCE_ID, 85);
            write_reg(REG_GAIN_POS, 300);
            write_reg(REG_GAIN_VEL, 12'h800);
            write_reg(REG_GAIN_POFS, 13'h1000);
            write_reg(REG_GAIN_PRT, 700);
            write_reg(REG_HEIGHT_WIN, 20'hAAAAA);
            write_reg(REG_ODOM_TMO, 13'h1555);
          end
          default: ;
        endcase
      end
      if (i == 200) hold_off_req = 1;
      if (i == 300) drain();
      if (i >= N_RANDOM - CALM_TAIL) calm = 1;

      sel = $urandom_range(0, 99);
      wide = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 29) == 0) now += $urandom_range(600, 3000);
      else if ($urandom_range(0, 39) == 0) now = $urandom;
      else now += $urandom_range(0, 8);
      it.time_ms = now;
      it.sender_id = ($urandom_range(0, 7) == 0) ? 8'($urandom) : r_source;
      it.valid_req = ($urandom_range(0, 11) != 0);
      it.heading = 16'($urandom);
      it.lean_limit = 14'($urandom);
      it.vel_north = rnd_val(wide);
      it.vel_east = rnd_val(wide);
      if (sel < 40) begin
        it.command = CMD_ODOM;
        pole_n = rnd_val(wide); pole_e = rnd_val(wide); pole_d = rnd_val(wide);
        it.pos_north = pole_n; it.pos_east = pole_e; it.pos_down = pole_d;
      end else begin
        it.command = (sel < 92) ? CMD_TICK : (sel < 96) ? CMD_RESET : 2'd3;
        it.pos_north = pole_n + rnd_val(wide);
        it.pos_east = pole_e + rnd_val(wide);
        it.pos_down = wide ? $urandom : pole_d + $signed($urandom_range(0, 32'h3FFFF))
                      - 32'sh1FFFF;
      end
      send(it, 0, ST_READY);
    end

    fork
      begin
        drain();
        if (errors == 0) $display("pendulum_state_feedback_controller_top: match");
        else $display("pendulum_state_feedback_controller_top: mismatch");
        $finish;
      end
    join
  end

endmodule

// ===== files.f =====
rtl/core/psfc_pkg.sv
rtl/core/psfc_if.sv
rtl/core/psfc_mac.sv
rtl/core/psfc_cordic.sv
rtl/core/pendulum_state_feedback_controller_top.sv
tb/tb_top.sv
